// File: hdl/vector4_alu_defines.svh
// ----------------------------------------------------------------------------
// vector4_alu_defines: assertion macros
// implication checks on the block clock, muted while reset is high
// ----------------------------------------------------------------------------
`ifndef VECTOR4_ALU_DEFINES_SVH
`define VECTOR4_ALU_DEFINES_SVH
`ifndef SYNTH
`define VA_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vector4_alu assertion failed");
`define VA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vector4_alu assertion failed");
`else
`define VA_ASSERT_IMPLY(lbl, ante, cons)
`define VA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hdl/va_pkg.sv
// ----------------------------------------------------------------------------
// va_pkg: shared types of the vector alu
// opcodes and the per-lane status flags
// ----------------------------------------------------------------------------
package va_pkg;

  localparam int OP_BITS = 4;

  typedef enum logic [OP_BITS-1:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_DOT      = 4'd4,
    OP_MAG      = 4'd5,
    OP_SCALE    = 4'd6,
    OP_UNIT     = 4'd7,
    OP_SCALE_TO = 4'd8
  } op_t;

  typedef struct packed {
    logic ovf;
    logic dz;
  } flags_t;

endpackage

// File: hdl/va_sqrt.sv
// ----------------------------------------------------------------------------
// va_sqrt: pipelined integer square root
// one root bit per stage, floor of the square root of the radicand
// ----------------------------------------------------------------------------
module va_sqrt #(
  parameter int OUT_W = 33
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [2*OUT_W-1:0]   rad,
  output logic [OUT_W-1:0]     root
);

  localparam int IW = 2 * OUT_W;
  localparam int RW = OUT_W + 3;

  logic [IW-1:0]    opnd [0:OUT_W];
  logic [RW-1:0]    rem  [0:OUT_W];
  logic [OUT_W-1:0] rt   [0:OUT_W];

  assign opnd[0] = rad;
  assign rem[0]  = '0;
  assign rt[0]   = '0;

  for (genvar k = 1; k <= OUT_W; k++) begin : g_stage
    logic [RW-1:0] t;
    logic [RW-1:0] trial;
    logic          ge;
    assign t     = {rem[k-1][RW-3:0], opnd[k-1][IW-1 -: 2]};
    assign trial = RW'({rt[k-1], 2'b01});
    assign ge    = (t >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        opnd[k] <= {opnd[k-1][IW-3:0], 2'b00};
        rem[k]  <= ge ? (t - trial) : t;
        rt[k]   <= {rt[k-1][OUT_W-2:0], ge};
      end
    end
  end

  assign root = rt[OUT_W];

endmodule

// File: hdl/va_div.sv
// ----------------------------------------------------------------------------
// va_div: pipelined unsigned divider
// restoring division, one quotient bit per stage
// ----------------------------------------------------------------------------
module va_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 33
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  logic [NUM_W-1:0] nr  [0:NUM_W];
  logic [DEN_W-1:0] rem [0:NUM_W];
  logic [DEN_W-1:0] dd  [0:NUM_W];
  logic [NUM_W-1:0] q   [0:NUM_W];

  assign nr[0]  = num;
  assign rem[0] = '0;
  assign dd[0]  = den;
  assign q[0]   = '0;

  for (genvar k = 1; k <= NUM_W; k++) begin : g_stage
    logic [DEN_W:0] t;
    logic [DEN_W:0] diff;
    logic           ge;
    assign t    = {rem[k-1], nr[k-1][NUM_W-1]};
    assign ge   = (t >= {1'b0, dd[k-1]});
    assign diff = t - {1'b0, dd[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        nr[k]  <= {nr[k-1][NUM_W-2:0], 1'b0};
        rem[k] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
        dd[k]  <= dd[k-1];
        q[k]   <= {q[k-1][NUM_W-2:0], ge};
      end
    end
  end

  assign quo = q[NUM_W];

endmodule

// File: hdl/va_lane.sv
// ----------------------------------------------------------------------------
// va_lane: one component lane of the vector alu
// add/sub, multiply, divide, unit and rescale of one component
// ----------------------------------------------------------------------------
module va_lane #(
  parameter int W  = 32,
  parameter int F  = 16,
  parameter int SQ = 33
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [va_pkg::OP_BITS-1:0] opcode,
  input  logic signed [W-1:0]     a,
  input  logic signed [W-1:0]     b,
  input  logic signed [W-1:0]     f,
  input  logic [W:0]              len,
  output logic [2*W-1:0]          prod,
  output logic                    prod_neg,
  output logic [W-1:0]            r,
  output va_pkg::flags_t          flags
);

  localparam int PW = 2 * W + F + 4;
  localparam int NW = W + F;
  localparam int DW = W + 1;
  localparam int OB = va_pkg::OP_BITS;

  typedef struct packed {
    logic [OB-1:0] op;
    logic          an;
    logic [W-1:0]  am;
    logic          bn;
    logic [W-1:0]  bm;
    logic          fn;
    logic [W-1:0]  fm;
    logic [W-1:0]  r;
    logic          ovf;
  } pre_t;

  typedef struct packed {
    logic [OB-1:0] op;
    logic          qneg;
    logic          dz;
    logic          fn;
    logic [W-1:0]  fm;
    logic [W-1:0]  r;
    logic          ovf;
  } post_t;

  function automatic logic [W:0] sat_pack(input logic neg, input logic [PW-1:0] mag);
    logic [PW-1:0] lim;
    logic [W-1:0]  low;
    logic          ovf;
    lim = PW'(1) << (W - 1);
    if (!neg) lim = lim - PW'(1);
    ovf = (mag > lim);
    low = ovf ? lim[W-1:0] : mag[W-1:0];
    return {ovf, neg ? W'(~low + 1'b1) : low};
  endfunction

  // stage 1: raw operands
  logic [OB-1:0] op1;
  logic [W-1:0]  a1, b1, f1;
  logic [W-1:0]  am, bm, fm;

  always_ff @(posedge clk) begin
    if (en) begin
      op1 <= opcode;
      a1  <= a;
      b1  <= b;
      f1  <= f;
    end
  end

  assign am = a1[W-1] ? W'(~a1 + 1'b1) : a1;
  assign bm = b1[W-1] ? W'(~b1 + 1'b1) : b1;
  assign fm = f1[W-1] ? W'(~f1 + 1'b1) : f1;

  // stage 2: product and sum
  logic [W-1:0]  mx, my;
  logic          mneg;
  logic [OB-1:0] op2;
  logic          an2, bn2, fn2;
  logic [W-1:0]  am2, bm2, fm2;
  logic [W:0]    as2;

  always_comb begin
    case (op1)
      va_pkg::OP_MUL, va_pkg::OP_DOT: begin
        mx = am; my = bm; mneg = a1[W-1] ^ b1[W-1];
      end
      va_pkg::OP_SCALE: begin
        mx = am; my = fm; mneg = a1[W-1] ^ f1[W-1];
      end
      default: begin
        mx = am; my = am; mneg = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2      <= op1;
      an2      <= a1[W-1];
      bn2      <= b1[W-1];
      fn2      <= f1[W-1];
      am2      <= am;
      bm2      <= bm;
      fm2      <= fm;
      prod     <= (2*W)'(mx) * (2*W)'(my);
      prod_neg <= mneg;
      // sub is b minus a
      if (op1 == va_pkg::OP_SUB) as2 <= {b1[W-1], b1} - {a1[W-1], a1};
      else as2 <= {a1[W-1], a1} + {b1[W-1], b1};
    end
  end

  // stage 3: componentwise results that need no divider
  logic [W:0] mul_pk;
  logic       as_ovf;
  logic [W-1:0] as_val;
  pre_t       pre_new;
  pre_t       pre_d [0:SQ];

  assign mul_pk = sat_pack(prod_neg, PW'(prod >> F));
  assign as_ovf = as2[W] ^ as2[W-1];
  assign as_val = as_ovf ? {as2[W], {(W-1){~as2[W]}}} : as2[W-1:0];

  always_comb begin
    pre_new = '{op: op2, an: an2, am: am2, bn: bn2, bm: bm2, fn: fn2, fm: fm2,
                r: '0, ovf: 1'b0};
    case (op2)
      va_pkg::OP_ADD, va_pkg::OP_SUB: begin
        pre_new.r = as_val; pre_new.ovf = as_ovf;
      end
      va_pkg::OP_MUL, va_pkg::OP_SCALE: begin
        pre_new.r = mul_pk[W-1:0]; pre_new.ovf = mul_pk[W];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) pre_d[0] <= pre_new;
  end

  // wait for the vector length
  for (genvar k = 1; k <= SQ; k++) begin : g_pre
    always_ff @(posedge clk) begin
      if (en) pre_d[k] <= pre_d[k-1];
    end
  end

  // divider feed: b/a for div, a/len for unit and scale_to
  pre_t          ps;
  logic          is_div;
  logic [NW-1:0] num;
  logic [DW-1:0] den;
  logic [NW-1:0] quo;
  post_t         post_new;
  post_t         post_d [1:NW];

  assign ps     = pre_d[SQ];
  assign is_div = (ps.op == va_pkg::OP_DIV);
  assign num    = is_div ? {ps.bm, {F{1'b0}}} : {ps.am, {F{1'b0}}};
  assign den    = is_div ? {1'b0, ps.am} : len;

  always_comb begin
    post_new.op   = ps.op;
    post_new.qneg = is_div ? (ps.an ^ ps.bn) : ps.an;
    post_new.dz   = (den == '0);
    post_new.fn   = ps.fn;
    post_new.fm   = ps.fm;
    post_new.r    = ps.r;
    post_new.ovf  = ps.ovf;
  end

  va_div #(.NUM_W(NW), .DEN_W(DW)) u_div (
    .clk (clk),
    .en  (en),
    .num (num),
    .den (den),
    .quo (quo)
  );

  always_ff @(posedge clk) begin
    if (en) post_d[1] <= post_new;
  end

  for (genvar k = 2; k <= NW; k++) begin : g_post
    always_ff @(posedge clk) begin
      if (en) post_d[k] <= post_d[k-1];
    end
  end

  // q1: pack quotient
  post_t      q1;
  logic [W-1:0] u1;
  logic       uovf1;
  logic [W:0] q_pk;

  assign q_pk = sat_pack(post_d[NW].qneg, PW'(quo));

  always_ff @(posedge clk) begin
    if (en) begin
      q1    <= post_d[NW];
      u1    <= post_d[NW].dz ? '0 : q_pk[W-1:0];
      uovf1 <= post_d[NW].dz ? 1'b0 : q_pk[W];
    end
  end

  // q2: rescale the unit component by the factor
  post_t        q2;
  logic [W-1:0] u2;
  logic         uovf2;
  logic [W-1:0] um;
  logic [2*W-1:0] sprod2;
  logic         sneg2;

  assign um = u1[W-1] ? W'(~u1 + 1'b1) : u1;

  always_ff @(posedge clk) begin
    if (en) begin
      q2     <= q1;
      u2     <= u1;
      uovf2  <= uovf1;
      sprod2 <= (2*W)'(um) * (2*W)'(q1.fm);
      sneg2  <= u1[W-1] ^ q1.fn;
    end
  end

  // q3: lane result
  logic [W:0] s_pk;

  assign s_pk = sat_pack(sneg2, PW'(sprod2 >> F));

  always_ff @(posedge clk) begin
    if (en) begin
      case (q2.op)
        va_pkg::OP_ADD, va_pkg::OP_SUB, va_pkg::OP_MUL, va_pkg::OP_SCALE: begin
          r <= q2.r; flags <= '{ovf: q2.ovf, dz: 1'b0};
        end
        va_pkg::OP_DIV, va_pkg::OP_UNIT: begin
          r <= u2; flags <= '{ovf: uovf2, dz: q2.dz};
        end
        va_pkg::OP_SCALE_TO: begin
          r <= s_pk[W-1:0]; flags <= '{ovf: uovf2 | s_pk[W], dz: q2.dz};
        end
        default: begin
          r <= '0; flags <= '{ovf: 1'b0, dz: 1'b0};
        end
      endcase
    end
  end

endmodule

// File: hdl/vector4_alu.sv
// ----------------------------------------------------------------------------
// vector4_alu: four-component fixed-point vector alu
// componentwise and reducing vector ops with saturation flags
// ----------------------------------------------------------------------------
// Takes one word per clock and returns one word per clock, in order, while
// the output is not stalled. The square-root pipeline (WORD_BITS+1 stages, one
// root bit each) feeds the divider pipeline (WORD_BITS+FRAC_BITS stages, one
// quotient bit each) that div, unit and scale_to run through; every opcode
// takes the same path length. The whole pipeline holds while a finished word
// waits at the output, so in_ready follows out_ready whenever the output stage
// is full.
`include "vector4_alu_defines.svh"

module vector4_alu #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [va_pkg::OP_BITS-1:0]   opcode,
  input  logic signed [WORD_BITS-1:0]  a_x,
  input  logic signed [WORD_BITS-1:0]  a_y,
  input  logic signed [WORD_BITS-1:0]  a_z,
  input  logic signed [WORD_BITS-1:0]  a_w,
  input  logic signed [WORD_BITS-1:0]  b_x,
  input  logic signed [WORD_BITS-1:0]  b_y,
  input  logic signed [WORD_BITS-1:0]  b_z,
  input  logic signed [WORD_BITS-1:0]  b_w,
  input  logic signed [WORD_BITS-1:0]  factor,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [WORD_BITS-1:0]  r_x,
  output logic signed [WORD_BITS-1:0]  r_y,
  output logic signed [WORD_BITS-1:0]  r_z,
  output logic signed [WORD_BITS-1:0]  r_w,
  output logic signed [WORD_BITS-1:0]  scalar_out,
  output logic                         overflow,
  output logic                         div_zero
);

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int SQ  = W + 1;
  localparam int DQ  = W + F;
  localparam int LAT = SQ + DQ + 7;
  localparam int PW  = 2 * W + F + 4;
  localparam int SW  = 2 * W + 3;
  localparam int QW  = 2 * SQ;
  localparam int OB  = va_pkg::OP_BITS;

  typedef struct packed {
    logic         ovf;
    logic [W-1:0] val;
  } scal_t;

  function automatic logic [W:0] sat_pack(input logic neg, input logic [PW-1:0] mag);
    logic [PW-1:0] lim;
    logic [W-1:0]  low;
    logic          ovf;
    lim = PW'(1) << (W - 1);
    if (!neg) lim = lim - PW'(1);
    ovf = (mag > lim);
    low = ovf ? lim[W-1:0] : mag[W-1:0];
    return {ovf, neg ? W'(~low + 1'b1) : low};
  endfunction

  // pipeline control: everything advances together
  logic          en;
  logic [LAT:1]  v;
  logic [OB-1:0] opd [1:LAT];

  assign en        = !v[LAT] || out_ready;
  assign in_ready  = en;
  assign out_valid = v[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[LAT-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) opd[1] <= opcode;
  end

  for (genvar k = 2; k <= LAT; k++) begin : g_op
    always_ff @(posedge clk) begin
      if (en) opd[k] <= opd[k-1];
    end
  end

  // lanes
  logic signed [W-1:0] a_v [4];
  logic signed [W-1:0] b_v [4];
  logic [2*W-1:0]      prod [4];
  logic                pneg [4];
  logic [W-1:0]        lr [4];
  va_pkg::flags_t      lf [4];
  logic [W:0]          len;

  assign a_v[0] = a_x;
  assign a_v[1] = a_y;
  assign a_v[2] = a_z;
  assign a_v[3] = a_w;
  assign b_v[0] = b_x;
  assign b_v[1] = b_y;
  assign b_v[2] = b_z;
  assign b_v[3] = b_w;

  for (genvar i = 0; i < 4; i++) begin : g_lane
    va_lane #(.W(W), .F(F), .SQ(SQ)) u_lane (
      .clk      (clk),
      .en       (en),
      .opcode   (opcode),
      .a        (a_v[i]),
      .b        (b_v[i]),
      .f        (factor),
      .len      (len),
      .prod     (prod[i]),
      .prod_neg (pneg[i]),
      .r        (lr[i]),
      .flags    (lf[i])
    );
  end

  // merge: sum of squares and dot sum at full precision
  logic [QW-1:0]        sq_sum, sq3;
  logic signed [SW-1:0] dot_sum, dot3;

  always_comb begin
    sq_sum  = '0;
    dot_sum = '0;
    for (int i = 0; i < 4; i++) begin
      sq_sum  = sq_sum + QW'(prod[i]);
      dot_sum = pneg[i] ? dot_sum - SW'(prod[i]) : dot_sum + SW'(prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq3  <= sq_sum;
      dot3 <= dot_sum;
    end
  end

  va_sqrt #(.OUT_W(SQ)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (sq3),
    .root (len)
  );

  // dot product truncates toward zero on the magnitude
  logic [SW-1:0] dot_mag;
  logic [W:0]    dot_pk;
  scal_t         dd [0:SQ-1];

  assign dot_mag = dot3[SW-1] ? SW'(~dot3 + 1'b1) : dot3;
  assign dot_pk  = sat_pack(dot3[SW-1], PW'(dot_mag >> F));

  always_ff @(posedge clk) begin
    if (en) dd[0] <= '{ovf: dot_pk[W], val: dot_pk[W-1:0]};
  end

  for (genvar k = 1; k < SQ; k++) begin : g_dot
    always_ff @(posedge clk) begin
      if (en) dd[k] <= dd[k-1];
    end
  end

  // scalar select once the length is known
  logic [W:0] mag_pk;
  scal_t      sc_new;
  scal_t      sc [0:DQ+2];

  assign mag_pk = sat_pack(1'b0, PW'(len));

  always_comb begin
    case (opd[3+SQ])
      va_pkg::OP_DOT: sc_new = dd[SQ-1];
      va_pkg::OP_MAG: sc_new = '{ovf: mag_pk[W], val: mag_pk[W-1:0]};
      default:        sc_new = '{ovf: 1'b0, val: '0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) sc[0] <= sc_new;
  end

  for (genvar k = 1; k <= DQ + 2; k++) begin : g_scal
    always_ff @(posedge clk) begin
      if (en) sc[k] <= sc[k-1];
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (en) begin
      r_x        <= lr[0];
      r_y        <= lr[1];
      r_z        <= lr[2];
      r_w        <= lr[3];
      scalar_out <= sc[DQ+2].val;
      overflow   <= sc[DQ+2].ovf | lf[0].ovf | lf[1].ovf | lf[2].ovf | lf[3].ovf;
      div_zero   <= lf[0].dz | lf[1].dz | lf[2].dz | lf[3].dz;
    end
  end

  `VA_ASSERT_IMPLY(a_dz_op, out_valid && div_zero, opd[LAT] == va_pkg::OP_DIV || opd[LAT] == va_pkg::OP_UNIT || opd[LAT] == va_pkg::OP_SCALE_TO)
  `VA_ASSERT_IMPLY(a_scalar_zero_vec, out_valid && (opd[LAT] == va_pkg::OP_DOT || opd[LAT] == va_pkg::OP_MAG), r_x == '0 && r_y == '0 && r_z == '0 && r_w == '0)
  `VA_ASSERT_NEXT(a_advance, en && v[LAT-1], out_valid)

endmodule
